[hw/rtl/psn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psn_pkg;

  // Store geometry
  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned AddrW     = $clog2(MaxPoints);
  localparam int unsigned CntW      = AddrW + 1;

  // Field widths
  localparam int unsigned CoordW = 24;
  localparam int unsigned SumW   = 40;
  localparam int unsigned AccW   = 64;
  localparam int unsigned ResW   = 32;

  // Status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatFew      = 2'd1;
  localparam logic [1:0] StatFlat     = 2'd2;
  localparam logic [1:0] StatOverflow = 2'd3;

  // Per-axis result of the reduction
  typedef struct packed {
    logic [ResW-1:0] scale;
    logic [ResW-1:0] offset;
    logic            flat;
  } axis_res_t;

endpackage

`default_nettype wire

[hw/rtl/psn_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Single-port synchronous RAM, registered read
module psn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/psn_axis.sv]
`timescale 1ns / 1ps
`default_nettype none

// One axis: mean by restoring division, deviation pass fed from the store,
// scale by bit-serial square-root search, then offset.
module psn_axis (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [psn_pkg::SumW-1:0]      sum_i,
  input  wire logic [psn_pkg::CntW-1:0]      n_i,
  // deviation pass: one stored coordinate per cycle while dev_vld_i
  input  wire logic                          dev_vld_i,
  input  wire logic [psn_pkg::CoordW-1:0]    dev_data_i,
  input  wire logic                          dev_done_i,
  output logic                               mean_done_o,
  output logic                               done_o,
  output psn_pkg::axis_res_t                 res_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDiv  = 3'd1;
  localparam logic [2:0] SDev  = 3'd2;
  localparam logic [2:0] SSqA  = 3'd3;
  localparam logic [2:0] SSqB  = 3'd4;
  localparam logic [2:0] SSqC  = 3'd5;
  localparam logic [2:0] SOffA = 3'd6;
  localparam logic [2:0] SOffB = 3'd7;

  localparam int unsigned MagW = psn_pkg::SumW;

  logic [2:0]             state_q, state_d;
  logic [MagW-1:0]        num_q, num_d;     // dividend shifting to quotient
  logic [MagW:0]          rem_q, rem_d;
  logic [5:0]             bit_q, bit_d;
  logic                   neg_q, neg_d;
  logic signed [MagW:0]   mean_q, mean_d;   // signed mean Q16.8
  logic [psn_pkg::AccW-1:0] acc_q, acc_d;
  logic [31:0]            s_q, s_d;
  logic [63:0]            cc_q, cc_d;       // c*c
  logic [63:0]            pl_q, pl_d;       // partial products of cc*A
  logic [63:0]            ph_q, ph_d;
  logic [63:0]            pm1_q, pm1_d;
  logic [63:0]            pm2_q, pm2_d;
  logic [63:0]            prod_q, prod_d;   // |m| * scale
  psn_pkg::axis_res_t     res_q, res_d;
  logic                   done_q, done_d;
  logic                   mdone_q, mdone_d;

  // combinational helpers
  logic [MagW:0]          rem_sh;
  logic signed [MagW+1:0] dev;
  logic [MagW:0]          adev;
  logic [63:0]            sq;
  logic [64:0]            acc_sum;
  logic [31:0]            cand;
  logic [63:0]            mid;
  logic [63:0]            hi, lo;
  logic [65:0]            thi;
  logic [MagW:0]          am;
  logic [63:0]            rnd;

  always_comb begin
    rem_sh  = {rem_q[MagW-1:0], num_q[MagW-1]};
    dev     = $signed({{(MagW+2-psn_pkg::CoordW){dev_data_i[psn_pkg::CoordW-1]}}, dev_data_i})
              - $signed({mean_q[MagW], mean_q});
    adev    = dev[MagW+1] ? (MagW+1)'(-dev) : dev[MagW:0];
    sq      = 64'(adev[31:0]) * 64'(adev[31:0]);
    acc_sum = {1'b0, acc_q} + {1'b0, sq};
    cand    = s_q | (32'd1 << bit_q[4:0]);
    mid     = {32'd0, pl_q[63:32]} + {32'd0, pm1_q[31:0]} + {32'd0, pm2_q[31:0]};
    lo      = {mid[31:0], pl_q[31:0]};
    hi      = ph_q + {32'd0, pm1_q[63:32]} + {32'd0, pm2_q[63:32]} + {32'd0, mid[63:32]};
    thi     = {54'd0, n_i - psn_pkg::CntW'(1), 1'b0};
    am      = mean_q[MagW] ? (MagW+1)'(-mean_q) : mean_q;
    rnd     = (prod_q + 64'd128) >> 8;
  end

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    neg_d   = neg_q;
    mean_d  = mean_q;
    acc_d   = acc_q;
    s_d     = s_q;
    cc_d    = cc_q;
    pl_d    = pl_q;
    ph_d    = ph_q;
    pm1_d   = pm1_q;
    pm2_d   = pm2_q;
    prod_d  = prod_q;
    res_d   = res_q;
    done_d  = 1'b0;
    mdone_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          neg_d   = sum_i[MagW-1];
          // |S| + n/2, the rounding bias
          num_d   = (sum_i[MagW-1] ? MagW'(-sum_i) : sum_i)
                    + MagW'(n_i >> 1);
          rem_d   = '0;
          bit_d   = 6'(MagW);
          state_d = SDiv;
        end
      end
      // restoring division, one quotient bit per cycle
      SDiv: begin
        if (rem_sh >= (MagW+1)'(n_i)) begin
          rem_d = rem_sh - (MagW+1)'(n_i);
          num_d = {num_q[MagW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          num_d = {num_q[MagW-2:0], 1'b0};
        end
        bit_d = bit_q - 6'd1;
        if (bit_q == 6'd1) begin
          state_d = SDev;
          mdone_d = 1'b1;
          acc_d   = '0;
          mean_d  = neg_q ? -$signed({1'b0, num_d}) : $signed({1'b0, num_d});
        end
      end
      // accumulate squared deviations, saturating
      SDev: begin
        if (dev_vld_i) begin
          acc_d = acc_sum[64] ? '1 : acc_sum[63:0];
        end
        if (dev_done_i) begin
          res_d.flat = 1'b0;
          s_d        = '0;
          bit_d      = 6'd31;
          state_d    = SSqA;
        end
      end
      SSqA: begin
        res_d.flat = (acc_q == '0);
        cc_d       = 64'(cand) * 64'(cand);
        state_d    = SSqB;
      end
      // cc * A as four 32x32 partial products
      SSqB: begin
        pl_d    = 64'(cc_q[31:0])  * 64'(acc_q[31:0]);
        pm1_d   = 64'(cc_q[31:0])  * 64'(acc_q[63:32]);
        pm2_d   = 64'(cc_q[63:32]) * 64'(acc_q[31:0]);
        ph_d    = 64'(cc_q[63:32]) * 64'(acc_q[63:32]);
        state_d = SSqC;
      end
      SSqC: begin
        if ({2'b0, hi} < thi || ({2'b0, hi} == thi && lo == '0)) begin
          s_d = cand;
        end
        if (bit_q == 6'd0) begin
          state_d = SOffA;
        end else begin
          bit_d   = bit_q - 6'd1;
          state_d = SSqA;
        end
      end
      SOffA: begin
        prod_d  = 64'(s_q) * 64'(am[31:0]);
        state_d = SOffB;
      end
      SOffB: begin
        res_d.scale = s_q;
        if (!mean_q[MagW] && mean_q != '0) begin
          res_d.offset = (rnd > 64'h8000_0000) ? 32'h8000_0000 : 32'(-rnd);
        end else begin
          res_d.offset = (rnd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
        end
        done_d  = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
      mdone_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      mdone_q <= mdone_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    bit_q  <= bit_d;
    neg_q  <= neg_d;
    mean_q <= mean_d;
    acc_q  <= acc_d;
    s_q    <= s_d;
    cc_q   <= cc_d;
    pl_q   <= pl_d;
    ph_q   <= ph_d;
    pm1_q  <= pm1_d;
    pm2_q  <= pm2_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign done_o      = done_q;
  assign mean_done_o = mdone_q;
  assign res_o       = res_q;

  // Assertions
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == SIdle) else $error("axis start while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("axis done held");
  a_dev_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dev_vld_i |-> state_q == SDev) else $error("deviation data outside pass");

endmodule

`default_nettype wire

[hw/rtl/point_set_normalization_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Point set normalization (Hartley). Points load one per cycle while
// in_ready_o is high into two 1024-entry stores, and running sums are kept.
// After the point marked last the unit takes no input until the result
// transfers: a restoring division gives each mean, a pass reads back the n
// stored points (one store read per cycle), then a 32-step square-root
// search, each step squaring the candidate, forming a cut 64x64 product and
// comparing, then the offset. Points beyond the store are dropped and
// reported by status 3 unless an axis is flat.
module point_set_normalization_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [23:0] point_x_i,
  input  wire logic [23:0] point_y_i,
  input  wire logic        last_point_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      scale_x_o,
  output logic [31:0]      scale_y_o,
  output logic [31:0]      offset_x_o,
  output logic [31:0]      offset_y_o,
  output logic [1:0]       status_o
);

  localparam logic [1:0] SLoad = 2'd0;
  localparam logic [1:0] SMean = 2'd1;
  localparam logic [1:0] SDev  = 2'd2;
  localparam logic [1:0] SWait = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [psn_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [psn_pkg::CntW-1:0]    rd_q, rd_d;
  logic [psn_pkg::SumW-1:0]    sumx_q, sumx_d, sumy_q, sumy_d;
  logic                        ovf_q, ovf_d;
  logic                        rvld_q, rvld_d;   // read data valid next cycle
  logic                        rdone_q, rdone_d;
  logic                        ax_done_q;
  logic                        out_valid_q;
  logic [31:0]                 sx_q, sy_q, ox_q, oy_q;
  logic [1:0]                  st_q;

  logic                        in_xfer, full, we, start, dev_done;
  logic [psn_pkg::AddrW-1:0]   addr;
  logic [23:0]                 rx, ry;
  logic                        mdx, mdy, dx, dy;
  psn_pkg::axis_res_t          resx, resy;

  assign full    = cnt_q == psn_pkg::CntW'(psn_pkg::MaxPoints);
  assign in_ready_o = (state_q == SLoad) && !out_valid_q;
  assign in_xfer = in_valid_i && in_ready_o;
  assign we      = in_xfer && !full;
  assign addr    = (state_q == SLoad) ? cnt_q[psn_pkg::AddrW-1:0]
                                      : rd_q[psn_pkg::AddrW-1:0];
  assign start   = in_xfer && last_point_i && (cnt_d >= psn_pkg::CntW'(2));
  assign dev_done = rdone_q;

  // Collection and readback control
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rd_d    = rd_q;
    sumx_d  = sumx_q;
    sumy_d  = sumy_q;
    ovf_d   = ovf_q;
    rvld_d  = 1'b0;
    rdone_d = 1'b0;
    case (state_q)
      SLoad: begin
        if (in_xfer) begin
          if (!full) begin
            cnt_d  = cnt_q + 1'b1;
            sumx_d = sumx_q + psn_pkg::SumW'($signed(point_x_i));
            sumy_d = sumy_q + psn_pkg::SumW'($signed(point_y_i));
          end else begin
            ovf_d = 1'b1;
          end
          if (last_point_i && cnt_d >= psn_pkg::CntW'(2)) begin
            state_d = SMean;
          end
        end
      end
      SMean: begin
        rd_d = '0;
        if (mdx) begin
          state_d = SDev;
        end
      end
      SDev: begin
        if (rd_q == cnt_q) begin
          rdone_d = rvld_q ? 1'b0 : 1'b1;
          if (!rvld_q) state_d = SWait;
        end else begin
          rvld_d = 1'b1;
          rd_d   = rd_q + 1'b1;
        end
      end
      SWait: begin
        if (ax_done_q) begin
          state_d = SLoad;
          cnt_d   = '0;
          sumx_d  = '0;
          sumy_d  = '0;
          ovf_d   = 1'b0;
        end
      end
      default: state_d = SLoad;
    endcase
    // short sets end at once
    if (state_q == SLoad && in_xfer && last_point_i && cnt_d < psn_pkg::CntW'(2)) begin
      cnt_d  = '0;
      sumx_d = '0;
      sumy_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
      cnt_q   <= '0;
      rd_q    <= '0;
      sumx_q  <= '0;
      sumy_q  <= '0;
      ovf_q   <= 1'b0;
      rvld_q  <= 1'b0;
      rdone_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rd_q    <= rd_d;
      sumx_q  <= sumx_d;
      sumy_q  <= sumy_d;
      ovf_q   <= ovf_d;
      rvld_q  <= rvld_d;
      rdone_q <= rdone_d;
    end
  end

  psn_ram #(.Width(24), .Depth(psn_pkg::MaxPoints)) u_ram_x (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(point_x_i), .rdata_o(rx));
  psn_ram #(.Width(24), .Depth(psn_pkg::MaxPoints)) u_ram_y (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(point_y_i), .rdata_o(ry));

  psn_axis u_axis_x (
    .clk_i, .rst_ni, .start_i(start), .sum_i(sumx_d), .n_i(cnt_d),
    .dev_vld_i(rvld_q), .dev_data_i(rx), .dev_done_i(dev_done),
    .mean_done_o(mdx), .done_o(dx), .res_o(resx));
  psn_axis u_axis_y (
    .clk_i, .rst_ni, .start_i(start), .sum_i(sumy_d), .n_i(cnt_d),
    .dev_vld_i(rvld_q), .dev_data_i(ry), .dev_done_i(dev_done),
    .mean_done_o(mdy), .done_o(dy), .res_o(resy));

  // Both axes run in lockstep; sums sampled at start, count held until the result
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ax_done_q   <= 1'b0;
    end else begin
      ax_done_q <= dx && dy && !mdy;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end else if ((in_xfer && last_point_i && cnt_d < psn_pkg::CntW'(2)) || (dx && dy)) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_point_i && cnt_d < psn_pkg::CntW'(2)) begin
      {sx_q, sy_q, ox_q, oy_q} <= '0;
      st_q <= psn_pkg::StatFew;
    end else if (dx && dy) begin
      if (resx.flat || resy.flat) begin
        {sx_q, sy_q, ox_q, oy_q} <= '0;
        st_q <= psn_pkg::StatFlat;
      end else begin
        sx_q <= resx.scale;
        sy_q <= resy.scale;
        ox_q <= resx.offset;
        oy_q <= resy.offset;
        st_q <= ovf_q ? psn_pkg::StatOverflow : psn_pkg::StatOk;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign scale_x_o   = sx_q;
  assign scale_y_o   = sy_q;
  assign offset_x_o  = ox_q;
  assign offset_y_o  = oy_q;
  assign status_o    = st_q;

  // Assertions
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= psn_pkg::CntW'(psn_pkg::MaxPoints)) else $error("count past store");
  a_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dx == dy) else $error("axes out of step");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != SLoad |-> !in_ready_o) else $error("accept while reducing");

endmodule

`default_nettype wire
